// ===== rtl/core/nf3_pkg.sv =====
// shared types, constants and register codes of the 3x3 neighborhood filter
`default_nettype none
package nf3_pkg;

  localparam int NF3_MAX_WIDTH = 1024;
  localparam int PIX_W = 8;
  localparam int CFG_DIM_W = 11;
  localparam int MODE_W = 2;
  localparam int ROW_W = 11;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_DIM_W-1:0] HEIGHT_LIMIT = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BOX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SALT_PEPPER = 2'd2;

  // floor(x / 9) == (x * BOX_RECIP) >> BOX_SHIFT for every box sum
  localparam logic [12:0] BOX_RECIP = 13'd7282;
  localparam int BOX_SHIFT = 16;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [8:0] window_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width_raw;
    logic [CFG_DIM_W-1:0] height_eff;
    logic [MODE_W-1:0]    mode;
    logic                 geom_wr;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/nf3_in_if.sv =====
// input stream channel: pixel samples and drain ticks
`default_nettype none
interface nf3_in_if import nf3_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  pixel_t pixel_value;

  modport source (output valid, output req_type, output pixel_value, input ready);
  modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nf3_out_if.sv =====
// output stream channel: filtered samples
`default_nettype none
interface nf3_out_if import nf3_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t out_value;
  logic   out_last;

  modport source (output valid, output out_value, output out_last, input ready);
  modport sink (input valid, input out_value, input out_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nf3_regs.sv =====
// apb configuration registers: image width, image height, filter mode
`default_nettype none
module nf3_regs import nf3_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [CFG_DIM_W-1:0] width;
  logic [CFG_DIM_W-1:0] height;
  logic [MODE_W-1:0]    mode;
  logic                 wr_en;
  logic [1:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WIDTH_RESET;
      height <= HEIGHT_RESET;
      mode   <= MODE_BOX;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  width  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height <= pwdata[CFG_DIM_W-1:0];
        REG_MODE:   mode   <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = CFG_DATA_W'(width);
      REG_HEIGHT: prdata = CFG_DATA_W'(height);
      REG_MODE:   prdata = CFG_DATA_W'(mode);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.width_raw = width;
    cfg.mode      = mode;
    if (height == '0) begin
      cfg.height_eff = CFG_DIM_W'(1);
    end else if (height > HEIGHT_LIMIT) begin
      cfg.height_eff = HEIGHT_LIMIT;
    end else begin
      cfg.height_eff = height;
    end
    cfg.geom_wr = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);
  end

endmodule
`default_nettype wire

// ===== rtl/core/nf3_line_store.sv =====
// one row of samples: single write port, registered read port
`default_nettype none
module nf3_line_store import nf3_pkg::*; #(
  parameter int DEPTH = NF3_MAX_WIDTH,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire pixel_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output pixel_t             rd_data
);

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nf3_kernel.sv =====
// window arithmetic: box blur, 1-2-1 gaussian, salt-and-pepper removal
`default_nettype none
module nf3_kernel import nf3_pkg::*; (
  input  wire window_t            win,
  input  wire logic [MODE_W-1:0]  mode,
  output pixel_t                  result
);

  logic [11:0] box_sum;
  logic [11:0] gauss_sum;
  logic [24:0] box_prod;
  logic        ring_zero;
  logic        ring_full;

  always_comb begin
    box_sum = '0;
    ring_zero = 1'b1;
    ring_full = 1'b1;
    for (int i = 0; i < 9; i++) begin
      box_sum = box_sum + 12'(win[i]);
      if (i != 4) begin
        ring_zero = ring_zero && (win[i] == '0);
        ring_full = ring_full && (win[i] == PIX_MAX);
      end
    end
    gauss_sum = 12'(win[0]) + {3'b0, win[1], 1'b0} + 12'(win[2])
              + {3'b0, win[3], 1'b0} + {2'b0, win[4], 2'b0} + {3'b0, win[5], 1'b0}
              + 12'(win[6]) + {3'b0, win[7], 1'b0} + 12'(win[8]);
    box_prod = 25'(box_sum) * 25'(BOX_RECIP);
  end

  always_comb begin
    case (mode)
      MODE_BOX:   result = box_prod[BOX_SHIFT +: PIX_W];
      MODE_GAUSS: result = gauss_sum[4 +: PIX_W];
      MODE_SALT_PEPPER: begin
        if (ring_zero) begin
          result = '0;
        end else if (ring_full) begin
          result = PIX_MAX;
        end else begin
          result = win[4];
        end
      end
      default:    result = win[4];
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/neighborhood_filter_3x3.sv =====
// top level of the streaming 3x3 neighborhood filter
//
// One 8-bit sample per beat in raster order; every beat can be accepted in consecutive
// cycles, so the sustained rate is one item per clock while the result receiver is ready.
// An accepted item passes an input stage (position counters and the registered read of
// both line stores) and then the window update and kernel arithmetic into the result
// register. The result for a center pixel is released by the item one row and one column
// later, and for the last column by the item at column 0 two rows down; after the frame,
// image_width + 1 drain ticks flush the last rows. Pixels outside the image read as zero.
// A drain tick before the frame's last pixel is consumed without effect. Writing width or
// height restarts the frame; the line stores need no clearing, as stale rows are masked
// by the row count.
`default_nettype none
module neighborhood_filter_3x3 import nf3_pkg::*; #(
  parameter int MAX_WIDTH = NF3_MAX_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  nf3_in_if.sink                     pixels,
  nf3_out_if.source                  results,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CMP_W = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;

  cfg_t cfg;

  nf3_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective geometry
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] width_clamp;
  logic [CW:0]      eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    width_ext = CMP_W'(cfg.width_raw);
    if (width_ext == '0) begin
      width_clamp = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_clamp = CMP_W'(MAX_WIDTH);
    end else begin
      width_clamp = width_ext;
    end
    eff_w = width_clamp[CW:0];
    eff_h = cfg.height_eff;
  end

  // input stage
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             drain_row;
  logic             item_skip;
  logic             accept;
  logic             take;
  pixel_t           in_v;
  logic             col_zero;
  logic             in_res;
  logic             in_last;
  logic [CW:0]      col_inc;
  logic             col_wrap;

  logic             s1_valid;
  logic             s1_go;
  pixel_t           s1_v;
  logic [CW-1:0]    s1_addr;
  logic             s1_zero;
  logic             s1_ge1;
  logic             s1_ge2;
  logic             s1_res;
  logic             s1_last;
  logic             s1_fwd;
  pixel_t           s1_fwd_t0;
  pixel_t           s1_fwd_t1;
  logic             fwd;
  logic             s1_adv;

  pixel_t           up_rd;
  pixel_t           lo_rd;
  pixel_t           t0_raw;
  pixel_t           t1_raw;
  pixel_t           t0;
  pixel_t           t1;

  logic             out_valid;
  pixel_t           out_value;
  logic             out_last;

  assign s1_go   = !out_valid || results.ready;
  assign s1_adv  = s1_valid && s1_go;
  assign pixels.ready = !s1_valid || s1_go;

  always_comb begin
    drain_row = row >= eff_h;
    item_skip = !drain_row && pixels.req_type;
    accept    = pixels.valid && pixels.ready;
    take      = accept && !item_skip;
    in_v      = drain_row ? '0 : pixels.pixel_value;
    col_zero  = col == '0;
    if (col_zero) begin
      in_res = (row >= ROW_W'(2)) && (row < eff_h + ROW_W'(2));
    end else begin
      in_res = (row >= ROW_W'(1)) && (row < eff_h + ROW_W'(1));
    end
    in_last  = col_zero && (row == eff_h + ROW_W'(1));
    col_inc  = {1'b0, col} + (CW + 1)'(1);
    col_wrap = col_inc >= eff_w;
    fwd      = s1_adv && (s1_addr == col);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.geom_wr) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (in_last) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_v      <= in_v;
      s1_addr   <= col;
      s1_zero   <= col_zero;
      s1_ge1    <= row >= ROW_W'(1);
      s1_ge2    <= row >= ROW_W'(2);
      s1_res    <= in_res;
      s1_last   <= in_last;
      s1_fwd    <= fwd;
      s1_fwd_t0 <= t1_raw;
      s1_fwd_t1 <= s1_v;
    end
  end

  // line stores, upper is two rows back, lower one row back
  nf3_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (t1_raw),
    .rd_en   (take),
    .rd_addr (col),
    .rd_data (up_rd)
  );

  nf3_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lower (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (s1_v),
    .rd_en   (take),
    .rd_addr (col),
    .rd_data (lo_rd)
  );

  // bypass when the previous beat wrote the same column
  always_comb begin
    t0_raw = s1_fwd ? s1_fwd_t0 : up_rd;
    t1_raw = s1_fwd ? s1_fwd_t1 : lo_rd;
    t0 = s1_ge2 ? t0_raw : '0;
    t1 = s1_ge1 ? t1_raw : '0;
  end

  // window and kernel
  window_t win;
  window_t filt_win;
  window_t win_next;
  pixel_t  filt_value;

  always_comb begin
    filt_win[0] = win[1];
    filt_win[1] = win[2];
    filt_win[2] = s1_zero ? '0 : t0;
    filt_win[3] = win[4];
    filt_win[4] = win[5];
    filt_win[5] = s1_zero ? '0 : t1;
    filt_win[6] = win[7];
    filt_win[7] = win[8];
    filt_win[8] = s1_zero ? '0 : s1_v;
    if (s1_last) begin
      win_next = '0;
    end else if (s1_zero) begin
      win_next    = '0;
      win_next[2] = t0;
      win_next[5] = t1;
      win_next[8] = s1_v;
    end else begin
      win_next = filt_win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.geom_wr) begin
      win <= '0;
    end else if (s1_adv) begin
      win <= win_next;
    end
  end

  nf3_kernel u_kernel (
    .win    (filt_win),
    .mode   (cfg.mode),
    .result (filt_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      out_value <= filt_value;
      out_last  <= s1_last;
    end
  end

  assign results.valid     = out_valid;
  assign results.out_value = out_value;
  assign results.out_last  = out_last;

endmodule
`default_nettype wire

// ===== sim/neighborhood_filter_3x3_tb.sv =====
// testbench of the 3x3 neighborhood filter: directed and random frames checked beat by beat against a model
`timescale 1ns / 100ps
module neighborhood_filter_3x3_tb;
  import nf3_pkg::*;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned END_WAIT_LIMIT = 100_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    pixel_t value;
    logic   last;
  } filtered_pixel_t;

  class window_filter_model;
    pixel_t two_rows_back [NF3_MAX_WIDTH];
    pixel_t one_row_back [NF3_MAX_WIDTH];
    pixel_t win [9];
    int unsigned row;
    int unsigned col;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [MODE_W-1:0] mode_reg;
    filtered_pixel_t expected_pixels [$];
    int unsigned mismatches;

    function new();
      foreach (two_rows_back[i]) begin
        two_rows_back[i] = '0;
        one_row_back[i] = '0;
      end
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mode_reg = MODE_BOX;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      row = 0;
      col = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > NF3_MAX_WIDTH) return NF3_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    function void set_register(logic [1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_WIDTH: begin
          width_reg = value[CFG_DIM_W-1:0];
          restart();
        end
        REG_HEIGHT: begin
          height_reg = value[CFG_DIM_W-1:0];
          restart();
        end
        REG_MODE: mode_reg = value[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function pixel_t filtered();
      int unsigned plain;
      int unsigned weighted;
      int unsigned ring;
      plain = 0;
      ring = 0;
      foreach (win[i]) begin
        plain += win[i];
        if (i != 4) ring += win[i];
      end
      // 1-2-1 kernel: edges count twice, center four times
      weighted = plain + win[1] + win[3] + win[5] + win[7] + 3 * win[4];
      case (mode_reg)
        MODE_BOX: return pixel_t'(plain / 9);
        MODE_GAUSS: return pixel_t'(weighted / 16);
        MODE_SALT_PEPPER: begin
          if (ring == 0) return '0;
          if (ring == 8 * PIX_MAX) return PIX_MAX;
          return win[4];
        end
        default: return win[4];
      endcase
    endfunction

    // returns 0 when the beat is an early drain and leaves no trace
    function bit take_item(logic kind, pixel_t value);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned cr;
      int unsigned cc;
      pixel_t top;
      pixel_t mid;
      pixel_t v;
      pixel_t res;
      bit hit;
      filtered_pixel_t exp_pix;
      w = eff_width();
      h = eff_height();
      r = row;
      c = col;
      v = value;
      res = '0;
      if (r < h) begin
        if (kind == REQ_DRAIN) return 0;
      end else begin
        v = '0;
      end
      top = (r >= 2) ? two_rows_back[c] : '0;
      mid = (r >= 1) ? one_row_back[c] : '0;
      two_rows_back[c] = one_row_back[c];
      one_row_back[c] = v;
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
        win[i*3+2] = '0;
      end
      if (c == 0) begin
        hit = (r >= 2) && (r - 2 < h);
        cr = r - 2;
        cc = w - 1;
        if (hit) res = filtered();
        foreach (win[i]) win[i] = '0;
      end else begin
        hit = (r >= 1) && (r - 1 < h);
        cr = r - 1;
        cc = c - 1;
      end
      win[2] = top;
      win[5] = mid;
      win[8] = v;
      if (hit && c != 0) res = filtered();
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
      if (hit) begin
        exp_pix.value = res;
        exp_pix.last = (cr == h - 1) && (cc == w - 1);
        expected_pixels = {expected_pixels, exp_pix};
        if (exp_pix.last) restart();
      end
      return 1;
    endfunction

    function void check_result(pixel_t value, logic last);
      filtered_pixel_t exp_pix;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: value %0d last %0b", value, last);
        return;
      end
      exp_pix = expected_pixels.pop_front();
      if (exp_pix.value !== value || exp_pix.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                   exp_pix.value, exp_pix.last, value, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic hold_off_req = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned items_taken = 0;
  int unsigned cycle_count = 0;

  window_filter_model sb = new();

  nf3_in_if pix_ch();
  nf3_out_if res_ch();

  neighborhood_filter_3x3 dut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_ch),
    .results(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("neighborhood_filter_3x3_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.out_value, res_ch.out_last);
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic pixel_t pick_pixel(int unsigned texture);
    int unsigned roll;
    roll = $urandom_range(99);
    case (texture)
      1: return (roll < 45) ? 8'd0 : (roll < 90) ? PIX_MAX : pixel_t'($urandom);
      2: return (roll < 92) ? PIX_MAX : (roll < 96) ? 8'd0 : pixel_t'($urandom);
      3: return (roll < 92) ? 8'd0 : (roll < 96) ? PIX_MAX : pixel_t'($urandom);
      default: return pixel_t'($urandom);
    endcase
  endfunction

  initial begin : result_pacing
    int unsigned stall_left;
    int unsigned stall_pct;
    int unsigned span;
    bit held;
    res_ch.ready <= 1'b0;
    stall_left = 0;
    stall_pct = 0;
    span = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = 256;
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      span--;
      if (hold_off_req && !held) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(index, value);
    @(posedge clk);
  endtask

  task automatic send_item(input logic kind, input pixel_t value);
    pix_ch.valid <= 1'b1;
    pix_ch.req_type <= kind;
    pix_ch.pixel_value <= value;
    do @(posedge clk); while (!pix_ch.ready);
    if (sb.take_item(kind, value)) items_taken++;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      pix_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // wait until every result is out and the pipeline is empty
  task automatic settle_block();
    pix_ch.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cut below w*h stops the frame early, leaving it for a geometry write to restart
  task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned cut,
                            input int unsigned texture);
    int unsigned n;
    n = w * h;
    for (int unsigned k = 0; k < n && k < cut; k++) begin
      if ($urandom_range(99) < 3) send_item(REQ_DRAIN, pixel_t'($urandom));
      send_item(REQ_PIXEL, pick_pixel(texture));
    end
    if (cut < n) return;
    for (int unsigned k = 0; k <= w; k++)
      send_item(($urandom_range(99) < 30) ? REQ_PIXEL : REQ_DRAIN, pixel_t'($urandom));
    if ($urandom_range(9) == 0) send_item(REQ_DRAIN, pixel_t'($urandom));
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned w;
    int unsigned h;
    int unsigned cut;
    int unsigned end_wait;
    bit rewrite;
    rst <= 1'b1;
    pix_ch.valid <= 1'b0;
    pix_ch.req_type <= REQ_PIXEL;
    pix_ch.pixel_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, early drain, late pixel, salt and pepper in a 3x3 frame
    send_gap_pct = 15;
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    write_reg(REG_MODE, MODE_BOX);
    send_item(REQ_DRAIN, 8'hA5);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PIXEL, PIX_MAX);
    send_item(REQ_PIXEL, 8'd128);
    send_item(REQ_PIXEL, PIX_MAX);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PIXEL, 8'd17);
    send_item(REQ_PIXEL, 8'd200);
    repeat (3) send_item(REQ_DRAIN, 8'h5A);
    send_item(REQ_DRAIN, 8'd0);
    settle_block();
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_MODE, MODE_SALT_PEPPER);
    for (int i = 0; i < 9; i++) send_item(REQ_PIXEL, (i == 4) ? 8'd0 : PIX_MAX);
    repeat (4) send_item(REQ_DRAIN, 8'd0);

    // largest geometry: width clamps to the maximum, frame cut short and restarted
    settle_block();
    write_reg(REG_MODE, MODE_GAUSS);
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 2047);
    send_frame(NF3_MAX_WIDTH, HEIGHT_LIMIT, NF3_MAX_WIDTH + 6, 0);
    settle_block();
    write_reg(REG_MODE, MODE_SALT_PEPPER);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 1500);
    send_frame(1, HEIGHT_LIMIT, HEIGHT_LIMIT, 2);
    settle_block();
    write_reg(REG_MODE, MODE_BOX);
    write_reg(REG_HEIGHT, 0);
    send_frame(1, 1, 1, 0);

    // receiver holds off while the sender keeps offering
    settle_block();
    write_reg(REG_WIDTH, 24);
    write_reg(REG_HEIGHT, 24);
    send_gap_pct = 0;
    hold_off_req <= 1'b1;
    base = items_taken;
    send_frame(24, 24, 24 * 24, 0);

    raw_w = 24;
    raw_h = 24;
    rewrite = 0;
    while (items_taken - base < RANDOM_ITEMS) begin
      if (rewrite || $urandom_range(9) < 6) begin
        settle_block();
        case ($urandom_range(19))
          0: raw_w = 0;
          1, 2, 3, 4, 5: raw_w = $urandom_range(9, 40);
          6: raw_w = $urandom_range(41, 64);
          default: raw_w = $urandom_range(1, 8);
        endcase
        if ($urandom_range(15) == 0) raw_h = 0;
        else raw_h = $urandom_range(1, ($urandom_range(3) == 0) ? 12 : 5);
        write_reg(REG_WIDTH, raw_w);
        write_reg(REG_HEIGHT, raw_h);
        if ($urandom_range(1) == 1) write_reg(REG_MODE, $urandom_range(3));
      end else if ($urandom_range(3) == 0) begin
        settle_block();
        write_reg(REG_MODE, $urandom_range(3));
      end
      w = (raw_w == 0) ? 1 : raw_w;
      h = (raw_h == 0) ? 1 : raw_h;
      case ($urandom_range(2))
        0: send_gap_pct = 0;
        1: send_gap_pct = 10;
        default: send_gap_pct = 35;
      endcase
      cut = w * h;
      if ($urandom_range(11) == 0) cut = $urandom_range(0, w * h - 1);
      rewrite = (cut < w * h);
      send_frame(w, h, cut, $urandom_range(3));
    end

    pix_ch.valid <= 1'b0;
    end_wait = 0;
    while (sb.expected_pixels.size() != 0 && end_wait < END_WAIT_LIMIT) begin
      @(posedge clk);
      end_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("neighborhood_filter_3x3_tb OK");
    end else begin
      $display("neighborhood_filter_3x3_tb NOT OK");
    end
    $finish;
  end

endmodule
